// ===== hw/rtl/cfq_pkg.sv =====
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants for the circular FIFO queue: operation codes,
// the input and result word layouts, the control state and the per-operation
// flags passed from the pointer logic to the top level.
// ----------------------------------------------------------------------------
package cfq_pkg;

  // Width of the value fields on both channels.
  localparam int unsigned DATA_W = 32;
  // Width of the capacity register.
  localparam int unsigned CAP_W  = 7;

  // Operation codes carried in the func field; any other code is status only.
  localparam logic [1:0] FUNC_ENQ    = 2'd0;
  localparam logic [1:0] FUNC_DEQ    = 2'd1;
  localparam logic [1:0] FUNC_STATUS = 2'd2;

  // One input word.
  typedef struct packed {
    logic [1:0]               func;
    logic signed [DATA_W-1:0] push_value;
  } cfq_in_t;

  // One result word.
  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] oldest_value;
    logic signed [DATA_W-1:0] newest_value;
    logic                     is_empty;
    logic                     is_full;
  } cfq_out_t;

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_LOAD
  } cfq_state_t;

  // Outcome of one operation, as decided from the pointers before the update.
  typedef struct packed {
    logic ok;          // operation succeeded (always for status)
    logic do_push;     // entry is written at the write index
    logic set_oldest;  // push into an empty queue: head becomes the pushed value
    logic load_oldest; // pop leaving entries: head comes from the memory
    logic now_empty;   // queue is empty after the operation
    logic now_full;    // queue is full after the operation
  } cfq_op_t;

endpackage

// ===== hw/rtl/circular_fifo_queue.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_queue
// Ring-buffer FIFO of signed values with a programmable capacity. Each input
// word enqueues, dequeues or only asks for status, and yields one result word.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data): one operation per word.
//   Result channel (out_valid, out_stall, out_data): success flag, oldest and
//   newest held value (all ones when empty), empty and full flags.
//   Config channel (cfg_valid, cfg_ready, cfg_data): writes the capacity,
//   clamped to 1..MAX_DEPTH, and empties the queue. Write only when idle.
// Timing:
//   An accepted word moves the sequencer to the load state, where the result
//   register takes its word once free; input stalls until then, so no new
//   word is taken before that load. The load state uses the registered read
//   of the entry memory that fetches the new head after a dequeue.
//   While the receiver stalls, the result register holds its word; the next
//   input word is still accepted and waits in the load cycle until the
//   result register drains.
// Reset:
//   Synchronous, active low. The queue is empty and the capacity is
//   MAX_DEPTH. Entry memory is not cleared; only written entries are read.
// ----------------------------------------------------------------------------
module circular_fifo_queue #(
  parameter int unsigned MAX_DEPTH  = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  cfq_pkg::cfq_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output cfq_pkg::cfq_out_t         out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [cfq_pkg::CAP_W-1:0] cfg_data
);

  import cfq_pkg::*;

  localparam int unsigned IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_DEPTH + 1);

  cfq_state_t            state_r, state_nxt;
  cfq_op_t               op;
  cfq_op_t               op_r;
  logic [IDX_W-1:0]      wr_addr;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] push_ext;
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] oldest_r;
  logic [VALUE_BITS-1:0] newest_r;
  logic [VALUE_BITS-1:0] oldest_cur;
  logic                  in_accept;
  logic                  cfg_we;
  logic                  load_out;
  logic                  out_valid_r;
  cfq_out_t              out_r, out_nxt;

  // Handshakes.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;

  // The pushed value, sign-extended or truncated to the stored width.
  assign push_ext = VALUE_BITS'(in_data.push_value);

  cfq_ptr #(
    .MAX_DEPTH (MAX_DEPTH),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_cap (cfg_data),
    .op_go   (in_accept),
    .func    (in_data.func),
    .op      (op),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr)
  );

  cfq_mem #(
    .DEPTH  (MAX_DEPTH),
    .WIDTH  (VALUE_BITS),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (in_accept && op.do_push),
    .wr_addr (wr_addr),
    .wr_data (push_ext),
    .rd_en   (in_accept && op.load_oldest),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Sequencer: accept in idle, then form the result once the register frees.
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Head value after this operation: fresh from memory after a pop.
  assign oldest_cur = op_r.load_oldest ? rd_data : oldest_r;

  // Result word.
  always_comb begin
    out_nxt.ok           = op_r.ok;
    out_nxt.is_empty     = op_r.now_empty;
    out_nxt.is_full      = op_r.now_full;
    if (op_r.now_empty) begin
      out_nxt.oldest_value = DATA_W'({VALUE_BITS{1'b1}});
      out_nxt.newest_value = DATA_W'({VALUE_BITS{1'b1}});
    end else begin
      out_nxt.oldest_value = DATA_W'(oldest_cur);
      out_nxt.newest_value = DATA_W'(newest_r);
    end
  end

  // Operation flags and cached head and tail values.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= op;
      if (op.do_push) begin
        newest_r <= push_ext;
      end
      if (op.set_oldest) begin
        oldest_r <= push_ext;
      end
    end else if (load_out && op_r.load_oldest) begin
      oldest_r <= rd_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Only one operation is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input accepted while an operation is in flight");

  // A capacity of at least one means empty and full never coincide.
  a_empty_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.is_empty && out_data.is_full))
    else $error("queue reported empty and full together");

  // An operation fails only on a full enqueue or an empty dequeue.
  a_fail_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> (out_data.is_empty || out_data.is_full))
    else $error("operation failed with room and entries available");

  // An empty queue reports all-ones head and tail values.
  a_empty_values: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_empty |->
      (out_data.oldest_value == DATA_W'({VALUE_BITS{1'b1}})) &&
      (out_data.newest_value == DATA_W'({VALUE_BITS{1'b1}})))
    else $error("empty queue reported stale values");

endmodule

// ===== hw/rtl/cfq_mem.sv =====
// ----------------------------------------------------------------------------
// cfq_mem
// Entry storage: a simple dual-port synchronous memory with one write port
// and one read port whose data is registered.
// ----------------------------------------------------------------------------
module cfq_mem #(
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data register holds its value until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/cfq_ptr.sv =====
// ----------------------------------------------------------------------------
// cfq_ptr
// Queue bookkeeping: read and write indices, entry count and the effective
// capacity. Decides the outcome of each operation and updates the pointers
// when the operation is started. A capacity write empties the queue.
// ----------------------------------------------------------------------------
module cfq_ptr #(
  parameter int unsigned MAX_DEPTH = 64,
  parameter int unsigned IDX_W     = 6,
  parameter int unsigned CNT_W     = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [cfq_pkg::CAP_W-1:0] cfg_cap,
  input  logic                      op_go,
  input  logic [1:0]                func,
  output cfq_pkg::cfq_op_t          op,
  output logic [IDX_W-1:0]          wr_addr,
  output logic [IDX_W-1:0]          rd_addr
);

  import cfq_pkg::*;

  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;
  logic [CMP_W-1:0] cfg_ext;
  logic             is_enq;
  logic             is_deq;
  logic             can_push;
  logic             can_pop;
  logic             do_pop;

  // Advance an index by one, wrapping to zero at the capacity.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] inc;
    inc = CNT_W'(idx) + CNT_W'(1);
    if (inc >= cap) begin
      return '0;
    end else begin
      return IDX_W'(inc);
    end
  endfunction

  // Clamp the written capacity to the range one to MAX_DEPTH.
  always_comb begin
    cfg_ext = CMP_W'(cfg_cap);
    if (cfg_ext == '0) begin
      cap_nxt = CNT_W'(1);
    end else if (cfg_ext > CMP_W'(MAX_DEPTH)) begin
      cap_nxt = CNT_W'(MAX_DEPTH);
    end else begin
      cap_nxt = CNT_W'(cfg_ext);
    end
  end

  // Operation decode and outcome.
  always_comb begin
    is_enq   = (func == FUNC_ENQ);
    is_deq   = (func == FUNC_DEQ);
    can_push = (cnt_r != cap_r);
    can_pop  = (cnt_r != '0);
    do_pop   = is_deq && can_pop;

    op.ok       = !(is_enq && !can_push) && !(is_deq && !can_pop);
    op.do_push  = is_enq && can_push;

    cnt_nxt    = cnt_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    if (op.do_push) begin
      cnt_nxt    = cnt_r + CNT_W'(1);
      wr_idx_nxt = next_slot(wr_idx_r, cap_r);
    end else if (do_pop) begin
      cnt_nxt    = cnt_r - CNT_W'(1);
      rd_idx_nxt = next_slot(rd_idx_r, cap_r);
    end

    op.now_empty   = (cnt_nxt == '0);
    op.now_full    = (cnt_nxt == cap_r);
    op.set_oldest  = op.do_push && !can_pop;
    op.load_oldest = do_pop && (cnt_nxt != '0);
  end

  // The write goes to the current write index; the head is read at the
  // read index that follows the pop.
  assign wr_addr = wr_idx_r;
  assign rd_addr = rd_idx_nxt;

  // Pointer, count and capacity registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
      cap_r    <= CNT_W'(MAX_DEPTH);
    end else if (cfg_we) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
      cap_r    <= cap_nxt;
    end else if (op_go) begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== tb/sv/cfq_checker.sv =====
// ----------------------------------------------------------------------------
// cfq_checker
// Watches the input, result and capacity channels of the circular FIFO queue.
// Keeps a shadow copy of the ring buffer, predicts the status word for every
// accepted operation and compares each accepted result word field by field.
// ----------------------------------------------------------------------------
module cfq_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  cfq_pkg::cfq_in_t          in_data,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  cfq_pkg::cfq_out_t         out_data,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [cfq_pkg::CAP_W-1:0] cfg_data,
  output int                        error_count,
  output int                        pending_count,
  output int                        checked_count
);

  import cfq_pkg::*;

  // Shadow of the queue contents and pointers.
  logic [DATA_W-1:0] shadow_mem [DEPTH];
  logic [5:0]        shadow_wr;
  logic [5:0]        shadow_rd;
  int unsigned       shadow_count;
  logic [CAP_W-1:0]  shadow_cap;

  // Status words predicted but not yet seen on the result channel.
  cfq_out_t status_q [$];

  int err_n;
  int seen_n;

  // A zero capacity acts as one entry, anything above the memory as full depth.
  function automatic int unsigned active_depth();
    if (shadow_cap == 0) return 1;
    if (shadow_cap > DEPTH) return DEPTH;
    return shadow_cap;
  endfunction

  function automatic logic [5:0] wrap_next(input logic [5:0] idx, input int unsigned depth);
    return (idx + 1 >= depth) ? 6'd0 : 6'(idx + 1);
  endfunction

  // Applies one operation to the shadow queue and returns the status word it yields.
  function automatic cfq_out_t apply_queue_op(input cfq_in_t w);
    cfq_out_t    r;
    int unsigned depth;
    depth = active_depth();
    r.ok  = 1'b1;
    case (w.func)
      FUNC_ENQ: begin
        if (shadow_count < depth) begin
          shadow_mem[shadow_wr] = w.push_value;
          shadow_count++;
          shadow_wr = wrap_next(shadow_wr, depth);
        end else begin
          r.ok = 1'b0;
        end
      end
      FUNC_DEQ: begin
        if (shadow_count > 0) begin
          shadow_count--;
          shadow_rd = wrap_next(shadow_rd, depth);
        end else begin
          r.ok = 1'b0;
        end
      end
      default: begin
        // Status and the spare code leave the queue alone.
      end
    endcase
    if (shadow_count == 0) begin
      r.oldest_value = '1;
      r.newest_value = '1;
    end else begin
      r.oldest_value = shadow_mem[shadow_rd];
      r.newest_value = shadow_mem[(shadow_wr == 0) ? depth - 1 : shadow_wr - 1];
    end
    r.is_empty = (shadow_count == 0);
    r.is_full  = (shadow_count >= depth);
    return r;
  endfunction

  // Capacity writes, then result comparison, then prediction of new words.
  always @(posedge clk) begin
    cfq_out_t want;
    if (!rst_n) begin
      shadow_cap   = CAP_W'(DEPTH);
      shadow_wr    = '0;
      shadow_rd    = '0;
      shadow_count = 0;
      status_q.delete();
      err_n  = 0;
      seen_n = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        shadow_cap   = cfg_data;
        shadow_wr    = '0;
        shadow_rd    = '0;
        shadow_count = 0;
      end
      if (out_valid && !out_stall) begin
        seen_n++;
        if (status_q.size() == 0) begin
          $error("result word arrived with no operation outstanding");
          err_n++;
        end else begin
          want = status_q.pop_front();
          if (out_data.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
            err_n++;
          end
          if (out_data.oldest_value !== want.oldest_value) begin
            $error("oldest_value: expected %0d, got %0d",
                   want.oldest_value, out_data.oldest_value);
            err_n++;
          end
          if (out_data.newest_value !== want.newest_value) begin
            $error("newest_value: expected %0d, got %0d",
                   want.newest_value, out_data.newest_value);
            err_n++;
          end
          if (out_data.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_data.is_empty);
            err_n++;
          end
          if (out_data.is_full !== want.is_full) begin
            $error("is_full: expected %0d, got %0d", want.is_full, out_data.is_full);
            err_n++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        status_q.push_back(apply_queue_op(in_data));
      end
    end
    error_count   <= err_n;
    checked_count <= seen_n;
    pending_count <= status_q.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the circular FIFO queue with a short directed sequence and then with
// random fill and drain bursts under many capacity settings, with random gaps
// on the input side and random stalls on the result side. The checker beside
// the queue predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import cfq_pkg::*;

  // Unassigned operation code; the queue treats it as status only.
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam int unsigned DEPTH = 64;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  cfq_in_t          in_data;
  logic             out_valid;
  logic             out_stall;
  cfq_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  int error_count;
  int pending_count;
  int checked_count;
  int words_sent;
  int cap_writes;
  bit gaps_on;
  bit stalls_on;

  // Capacities for the random phases; the last two are drawn at run time.
  logic [CAP_W-1:0] cap_plan [10] = '{7'd2, 7'd0, 7'd127, 7'd5, 7'd1,
                                      7'd64, 7'd3, 7'd100, 7'd0, 7'd0};

  circular_fifo_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  cfq_checker #(.DEPTH(DEPTH)) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung run.
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random push value with the extremes mixed in.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // Number of entries a capacity setting really gives; sizes the bursts.
  function automatic int usable_depth(input logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return c;
  endfunction

  // Sends one operation word and returns at the edge where it is taken.
  task automatic send_word(input logic [1:0] f, input logic [DATA_W-1:0] v);
    int      gap;
    cfq_in_t w;
    gap          = gaps_on ? pick_gap() : 0;
    w.func       = f;
    w.push_value = v;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Holds off input until every outstanding result word has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the capacity register once the queue is idle.
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  // Result-side stalls in runs of random length.
  initial begin
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (stalls_on && $urandom_range(0, 2) == 0) hold = pick_gap();
      end
    end
  end

  // Reset, directed operations, random phases and the verdict.
  initial begin
    int         phase_words;
    int         burst;
    int         k;
    int         eff;
    bit         filling;
    logic [1:0] f;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    gaps_on    = 1'b1;
    stalls_on  = 1'b1;
    words_sent = 0;
    cap_writes = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty queue at full capacity: status, spare code and a failing dequeue.
    send_word(FUNC_STATUS, 32'h0);
    send_word(FUNC_SPARE, 32'h5555_5555);
    send_word(FUNC_DEQ, 32'h0);
    // Extreme values in, then out again past empty.
    send_word(FUNC_ENQ, 32'h7FFF_FFFF);
    send_word(FUNC_ENQ, 32'h8000_0000);
    send_word(FUNC_ENQ, 32'hFFFF_FFFF);
    send_word(FUNC_ENQ, 32'h0000_0000);
    send_word(FUNC_STATUS, 32'hAAAA_AAAA);
    send_word(FUNC_DEQ, 32'h0);
    send_word(FUNC_DEQ, 32'h0);
    send_word(FUNC_DEQ, 32'h0);
    send_word(FUNC_SPARE, 32'h0);
    send_word(FUNC_DEQ, 32'h0);
    send_word(FUNC_DEQ, 32'h0);

    // Single-entry queue: full after one push.
    set_capacity(7'd1);
    send_word(FUNC_ENQ, 32'h1234_5678);
    send_word(FUNC_ENQ, 32'h0BAD_F00D);
    send_word(FUNC_STATUS, 32'h0);
    send_word(FUNC_DEQ, 32'h0);
    send_word(FUNC_DEQ, 32'h0);
    send_word(FUNC_ENQ, 32'h7FFF_FFFF);

    // Zero capacity behaves as one entry.
    set_capacity(7'd0);
    send_word(FUNC_ENQ, 32'h0000_0005);
    send_word(FUNC_ENQ, 32'h0000_0006);
    send_word(FUNC_DEQ, 32'h0);

    // Random phases: alternating fill and drain bursts with some noise.
    cap_plan[8] = CAP_W'($urandom_range(1, 64));
    cap_plan[9] = CAP_W'($urandom_range(0, 127));
    for (int p = 0; p < 10; p++) begin
      set_capacity(cap_plan[p]);
      gaps_on     = ($urandom_range(0, 3) != 0);
      stalls_on   = ($urandom_range(0, 3) != 0);
      eff         = usable_depth(cap_plan[p]);
      phase_words = (eff >= 32) ? 100 : 40;
      filling     = 1'b1;
      k           = 0;
      while (k < phase_words) begin
        burst = $urandom_range(1, eff + 2);
        for (int i = 0; i < burst && k < phase_words; i++) begin
          if ($urandom_range(0, 9) == 0) f = 2'($urandom_range(0, 3));
          else f = filling ? FUNC_ENQ : FUNC_DEQ;
          if ($urandom_range(0, 49) == 0) wait_drained();
          send_word(f, pick_value());
          k++;
        end
        filling = !filling;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d operation words under %0d capacity writes, capacities 0 through 127.",
             words_sent, cap_writes);
    $display("Compared %0d result words across fill, drain and index wrap.", checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
